// ===== src/mtt_pkg.sv =====
// shared widths, latencies, register indexes and sideband types for the move-toward-target step
// no dependencies
package mtt_pkg;

	localparam int CW = 24;
	localparam int DW = CW + 1;
	localparam int SPW = 23;
	localparam int SQW = 2 * DW;
	localparam int RTW = DW;
	localparam int NW = DW + SPW;
	localparam int QW = SPW;
	localparam int SQRT_LAT = RTW;
	localparam int DIV_LAT = QW;

	typedef enum logic [1:0] {
		REG_DEST_X = 2'd0,
		REG_DEST_Y = 2'd1,
		REG_SPEED  = 2'd2,
		REG_TOL    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [CW-1:0] pos_x;
		logic signed [CW-1:0] pos_y;
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dy;
	} side_t;

	typedef struct packed {
		side_t side;
		logic  arrived;
	} mside_t;

endpackage

// ===== src/mtt_isqrt.sv =====
// pipelined floor square root, one result bit per register stage
// depends on mtt_pkg
module mtt_isqrt import mtt_pkg::*; (
	input  logic           clk,
	input  logic           en,
	input  logic [SQW-1:0] rad,
	output logic [RTW-1:0] root
);

	logic [SQW-1:0] rad_s  [RTW];
	logic [RTW:0]   rem_s  [RTW];
	logic [RTW-1:0] root_s [RTW];
	logic [SQW-1:0] rad_i  [RTW];
	logic [RTW:0]   rem_i  [RTW];
	logic [RTW-1:0] root_i [RTW];
	logic [SQW-1:0] rad_n  [RTW];
	logic [RTW:0]   rem_n  [RTW];
	logic [RTW-1:0] root_n [RTW];

	always_comb begin
		logic [RTW+2:0] r2;
		logic [RTW+2:0] trial;
		rad_i[0] = rad;
		rem_i[0] = '0;
		root_i[0] = '0;
		for (int k = 1; k < RTW; k++) begin
			rad_i[k] = rad_s[k-1];
			rem_i[k] = rem_s[k-1];
			root_i[k] = root_s[k-1];
		end
		for (int k = 0; k < RTW; k++) begin
			r2 = {rem_i[k], rad_i[k][SQW-1 -: 2]};
			trial = {1'b0, root_i[k], 2'b01};
			if (r2 >= trial) begin
				rem_n[k] = (RTW+1)'(r2 - trial);
				root_n[k] = {root_i[k][RTW-2:0], 1'b1};
			end else begin
				rem_n[k] = r2[RTW:0];
				root_n[k] = {root_i[k][RTW-2:0], 1'b0};
			end
			rad_n[k] = rad_i[k] << 2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < RTW; k++) begin
				rad_s[k] <= rad_n[k];
				rem_s[k] <= rem_n[k];
				root_s[k] <= root_n[k];
			end
		end
	end

	assign root = root_s[RTW-1];

endmodule

// ===== src/mtt_div.sv =====
// pipelined restoring divider, one quotient bit per register stage
// depends on mtt_pkg; quotient must fit QW bits
module mtt_div import mtt_pkg::*; (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);

	logic [DW-1:0] rem_s [QW];
	logic [QW-1:0] low_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [QW-1:0] q_s   [QW];
	logic [DW-1:0] rem_i [QW];
	logic [QW-1:0] low_i [QW];
	logic [DW-1:0] den_i [QW];
	logic [QW-1:0] q_i   [QW];
	logic [DW-1:0] rem_n [QW];
	logic [QW-1:0] q_n   [QW];

	always_comb begin
		logic [DW:0] r2;
		rem_i[0] = num[NW-1:QW];
		low_i[0] = num[QW-1:0];
		den_i[0] = den;
		q_i[0] = '0;
		for (int k = 1; k < QW; k++) begin
			rem_i[k] = rem_s[k-1];
			low_i[k] = low_s[k-1];
			den_i[k] = den_s[k-1];
			q_i[k] = q_s[k-1];
		end
		for (int k = 0; k < QW; k++) begin
			r2 = {rem_i[k], low_i[k][QW-1]};
			if (r2 >= {1'b0, den_i[k]}) begin
				rem_n[k] = DW'(r2 - {1'b0, den_i[k]});
				q_n[k] = {q_i[k][QW-2:0], 1'b1};
			end else begin
				rem_n[k] = r2[DW-1:0];
				q_n[k] = {q_i[k][QW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QW; k++) begin
				rem_s[k] <= rem_n[k];
				low_s[k] <= low_i[k] << 1;
				den_s[k] <= den_i[k];
				q_s[k] <= q_n[k];
			end
		end
	end

	assign quo = q_s[QW-1];

endmodule

// ===== src/move_toward_target_step.sv =====
// top level: constant-speed approach of a 2d point toward a destination
// depends on mtt_pkg, mtt_isqrt, mtt_div
//
// input stream s_*: one transfer per frame tick, s_tdata carries the position.
// output stream m_*: one transfer per input, new position, step and arrived flag.
// apb port: dest_x at 0x0, dest_y at 0x4, step_speed at 0x8, arrive_tolerance
// at 0xc; write only while no transfer is in flight.
// pipeline: 4 stages of difference and squares, 25 stages of square root,
// 2 stages of scaling, 23 stages of division, one output register.
// throughput: one transfer per cycle unless the receiver stalls; each root and
// quotient bit has its own pipeline stage.
// reset clears all valid bits and loads the register reset values.
// when the receiver stalls the whole pipeline holds and s_tready falls;
// nothing is lost or repeated.
module move_toward_target_step import mtt_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [47:0]  s_tdata,  // pos_x, pos_y
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,  // new_x, new_y, move_x, move_y, zero fill
	output logic         m_tuser,  // arrived
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	logic signed [CW-1:0] dest_x_q;
	logic signed [CW-1:0] dest_y_q;
	logic [SPW-1:0] speed_q;
	logic [SPW-1:0] tol_q;
	reg_idx_t ridx;
	logic en;

	assign pready = 1'b1;
	assign ridx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_x_q <= '0;
			dest_y_q <= '0;
			speed_q <= SPW'(256);
			tol_q <= SPW'(256);
		end else if (psel && penable && pwrite) begin
			unique case (ridx)
				REG_DEST_X: dest_x_q <= pwdata[CW-1:0];
				REG_DEST_Y: dest_y_q <= pwdata[CW-1:0];
				REG_SPEED:  speed_q <= pwdata[SPW-1:0];
				REG_TOL:    tol_q <= pwdata[SPW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_DEST_X: prdata = 32'(unsigned'(dest_x_q));
			REG_DEST_Y: prdata = 32'(unsigned'(dest_y_q));
			REG_SPEED:  prdata = 32'(speed_q);
			REG_TOL:    prdata = 32'(tol_q);
			default:    prdata = '0;
		endcase
	end

	// front stages
	logic out_v_q;
	logic v_s1, v_s2, v_s3, v_s4;
	side_t side_s1, side_s2, side_s3, side_s4;
	logic [DW-1:0] ax_s2, ay_s2;
	logic [SQW-1:0] sqx_s3, sqy_s3, sum_s4;
	logic signed [CW-1:0] in_x, in_y;

	assign en = !out_v_q || m_tready;
	assign s_tready = en;
	assign in_x = s_tdata[CW-1:0];
	assign in_y = s_tdata[2*CW-1:CW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.pos_x <= in_x;
			side_s1.pos_y <= in_y;
			side_s1.dx <= DW'(dest_x_q) - DW'(in_x);
			side_s1.dy <= DW'(dest_y_q) - DW'(in_y);
			side_s2 <= side_s1;
			ax_s2 <= side_s1.dx[DW-1] ? DW'(-side_s1.dx) : side_s1.dx;
			ay_s2 <= side_s1.dy[DW-1] ? DW'(-side_s1.dy) : side_s1.dy;
			side_s3 <= side_s2;
			sqx_s3 <= SQW'(ax_s2) * SQW'(ax_s2);
			sqy_s3 <= SQW'(ay_s2) * SQW'(ay_s2);
			side_s4 <= side_s3;
			sum_s4 <= sqx_s3 + sqy_s3;
		end
	end

	// square root with matching sideband delay
	logic [RTW-1:0] root_len;
	logic sqv_s [SQRT_LAT];
	side_t sqd_s [SQRT_LAT];

	mtt_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.rad  (sum_s4),
		.root (root_len)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SQRT_LAT; k++) sqv_s[k] <= 1'b0;
		end else if (en) begin
			sqv_s[0] <= v_s4;
			for (int k = 1; k < SQRT_LAT; k++) sqv_s[k] <= sqv_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqd_s[0] <= side_s4;
			for (int k = 1; k < SQRT_LAT; k++) sqd_s[k] <= sqd_s[k-1];
		end
	end

	// arrival decision and scaling
	logic v_s30, v_s31;
	mside_t ms_s30, ms_s31;
	logic [RTW-1:0] dist_s30, dist_s31;
	logic [NW-1:0] px_s30, py_s30, numx_s31, numy_s31;
	side_t sd;
	logic [DW-1:0] axe, aye;
	logic [SPW:0] lim;

	assign sd = sqd_s[SQRT_LAT-1];
	assign axe = sd.dx[DW-1] ? DW'(-sd.dx) : sd.dx;
	assign aye = sd.dy[DW-1] ? DW'(-sd.dy) : sd.dy;
	assign lim = {1'b0, tol_q} + {1'b0, speed_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s30 <= 1'b0;
			v_s31 <= 1'b0;
		end else if (en) begin
			v_s30 <= sqv_s[SQRT_LAT-1];
			v_s31 <= v_s30;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ms_s30.side <= sd;
			ms_s30.arrived <= (root_len == '0) || (root_len < RTW'(lim));
			dist_s30 <= root_len;
			px_s30 <= NW'(axe) * NW'(speed_q);
			py_s30 <= NW'(aye) * NW'(speed_q);
			ms_s31 <= ms_s30;
			dist_s31 <= dist_s30;
			numx_s31 <= px_s30 + NW'(dist_s30 >> 1);
			numy_s31 <= py_s30 + NW'(dist_s30 >> 1);
		end
	end

	// division with matching sideband delay
	logic [QW-1:0] qx, qy;
	logic dvv_s [DIV_LAT];
	mside_t dvd_s [DIV_LAT];

	mtt_div u_div_x (
		.clk (clk),
		.en  (en),
		.num (numx_s31),
		.den (dist_s31),
		.quo (qx)
	);

	mtt_div u_div_y (
		.clk (clk),
		.en  (en),
		.num (numy_s31),
		.den (dist_s31),
		.quo (qy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_LAT; k++) dvv_s[k] <= 1'b0;
		end else if (en) begin
			dvv_s[0] <= v_s31;
			for (int k = 1; k < DIV_LAT; k++) dvv_s[k] <= dvv_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvd_s[0] <= ms_s31;
			for (int k = 1; k < DIV_LAT; k++) dvd_s[k] <= dvd_s[k-1];
		end
	end

	// output stage
	function automatic logic signed [CW-1:0] sat_add(logic signed [CW-1:0] p,
			logic signed [DW-1:0] m);
		logic signed [DW:0] s;
		s = (DW+1)'(p) + (DW+1)'(m);
		if (s[DW:CW-1] == '0 || s[DW:CW-1] == '1) return s[CW-1:0];
		return s[DW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
	endfunction

	mside_t mo;
	logic signed [DW-1:0] mvx, mvy;
	logic signed [CW-1:0] new_x_q, new_y_q;
	logic signed [DW-1:0] move_x_q, move_y_q;
	logic arrived_q;

	assign mo = dvd_s[DIV_LAT-1];
	assign mvx = mo.side.dx[DW-1] ? -DW'(qx) : DW'(qx);
	assign mvy = mo.side.dy[DW-1] ? -DW'(qy) : DW'(qy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= dvv_s[DIV_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			arrived_q <= mo.arrived;
			if (mo.arrived) begin
				new_x_q <= dest_x_q;
				new_y_q <= dest_y_q;
				move_x_q <= mo.side.dx;
				move_y_q <= mo.side.dy;
			end else begin
				new_x_q <= sat_add(mo.side.pos_x, mvx);
				new_y_q <= sat_add(mo.side.pos_y, mvy);
				move_x_q <= mvx;
				move_y_q <= mvy;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = {6'b0, move_y_q, move_x_q, new_y_q, new_x_q};
	assign m_tuser = arrived_q;

endmodule

// ===== test/tb_move_toward_target_step.sv =====
// testbench for move_toward_target_step: stream stimulus, apb register writes,
// an independent position-update predictor and a fifo of expected moves
// depends on mtt_pkg and move_toward_target_step
`timescale 1ns / 100ps

module tb_move_toward_target_step import mtt_pkg::*; ();

	localparam int LATENCY = 55;
	localparam int WATCHDOG = 20000;
	localparam int HOLD_CYCLES = 200;

	typedef struct packed {
		logic signed [CW-1:0] new_x;
		logic signed [CW-1:0] new_y;
		logic signed [DW-1:0] move_x;
		logic signed [DW-1:0] move_y;
		logic                 arrived;
	} step_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready;
	logic [47:0] s_tdata;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [103:0] m_tdata;
	logic m_tuser;
	logic psel, penable, pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;

	logic signed [CW-1:0] dest_x_q, dest_y_q;
	logic [SPW-1:0] speed_q, tol_q;
	step_t expected_moves[$];
	int errors = 0;
	int idle_cycles = 0;
	int send_idle_pct, recv_stall_pct;
	int hold_off = 0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;

	move_toward_target_step dut (.*);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic logic [63:0] isqrt_floor(logic [63:0] v);
		logic [63:0] r;
		logic [63:0] c;
		r = 0;
		for (int k = 31; k >= 0; k--) begin
			c = r | (64'd1 << k);
			if (c * c <= v) r = c;
		end
		return r;
	endfunction

	function automatic logic signed [DW-1:0] scale_axis(logic signed [DW-1:0] d,
			logic [63:0] len);
		logic [63:0] mag, q;
		mag = d < 0 ? 64'(-d) : 64'(d);
		q = (mag * 64'(speed_q) + len / 2) / len;
		return d < 0 ? -DW'(q) : DW'(q);
	endfunction

	function automatic logic signed [CW-1:0] clamp_coord(longint v);
		if (v > 64'sd8388607) return 24'sh7fffff;
		if (v < -64'sd8388608) return 24'sh800000;
		return CW'(v);
	endfunction

	function automatic step_t predict_step(logic signed [CW-1:0] px,
			logic signed [CW-1:0] py);
		step_t r;
		logic signed [DW-1:0] dx, dy;
		logic [63:0] ax, ay, len;
		dx = DW'(dest_x_q) - DW'(px);
		dy = DW'(dest_y_q) - DW'(py);
		ax = dx < 0 ? 64'(-dx) : 64'(dx);
		ay = dy < 0 ? 64'(-dy) : 64'(dy);
		len = isqrt_floor(ax * ax + ay * ay);
		if (len != 0 && len >= 64'(speed_q) + 64'(tol_q)) begin
			r.move_x = scale_axis(dx, len);
			r.move_y = scale_axis(dy, len);
			r.new_x = clamp_coord(longint'(px) + longint'(r.move_x));
			r.new_y = clamp_coord(longint'(py) + longint'(r.move_y));
			r.arrived = 1'b0;
		end else begin
			r.move_x = dx;
			r.move_y = dy;
			r.new_x = dest_x_q;
			r.new_y = dest_y_q;
			r.arrived = 1'b1;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= data; penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_DEST_X: dest_x_q = data[CW-1:0];
			REG_DEST_Y: dest_y_q = data[CW-1:0];
			REG_SPEED:  speed_q = data[SPW-1:0];
			REG_TOL:    tol_q = data[SPW-1:0];
			default: ;
		endcase
	endtask

	task automatic send_position(logic signed [CW-1:0] px, logic signed [CW-1:0] py);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {py, px};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_moves.push_back(predict_step(px, py));
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_moves.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic configure(logic signed [CW-1:0] tx, logic signed [CW-1:0] ty,
			logic [SPW-1:0] sp, logic [SPW-1:0] tl);
		drain();
		write_reg(REG_DEST_X, 32'(tx));
		write_reg(REG_DEST_Y, 32'(ty));
		write_reg(REG_SPEED, 32'(sp));
		write_reg(REG_TOL, 32'(tl));
	endtask

	function automatic logic signed [CW-1:0] rand_coord();
		case ($urandom_range(3))
			0: return CW'($urandom);
			1: return CW'($signed($urandom_range(4000)) - 2000);
			2: return $urandom_range(1) ? 24'sh7fffff - CW'($urandom_range(300))
				: 24'sh800000 + CW'($urandom_range(300));
			default: return dest_x_q + CW'($signed($urandom_range(2048)) - 1024);
		endcase
	endfunction

	task automatic test_directed();
		send_position(0, 0);
		send_position(24'sh7fffff, 24'sh7fffff);
		send_position(24'sh800000, 24'sh800000);
		send_position(24'sh7fffff, 24'sh800000);
		send_position(256, 0);
		send_position(511, 0);
		send_position(512, 0);
		send_position(-600, 600);
		configure(24'sh7fffff, 24'sh800000, 23'h7fffff, 0);
		send_position(24'sh800000, 24'sh7fffff);
		send_position(24'sh7fffff, 24'sh800000);
		send_position(0, 0);
		configure(24'sh800000, 24'sh7fffff, 0, 0);
		send_position(24'sh800000, 24'sh7fffff);
		send_position(24'sh800001, 24'sh7fffff);
		send_position(0, 0);
		configure(0, 0, 23'h7fffff, 23'h7fffff);
		send_position(24'sh800000, 24'sh800000);
		send_position(1000, -1000);
		configure(100, -100, 23'h400000, 0);
		send_position(24'sh7fffff, 24'sh7fffff);
		send_position(24'sh800000, 24'sh800000);
	endtask

	task automatic test_random(int n, int sidle, int rstall);
		send_idle_pct = sidle;
		recv_stall_pct = rstall;
		for (int i = 0; i < n; i++) send_position(rand_coord(), rand_coord());
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 1'b1;
		for (int i = 0; i < 100; i++) send_position(rand_coord(), rand_coord());
	endtask

	always @(posedge clk) begin
		step_t got, want;
		if (m_tvalid && m_tready) begin
			got = {m_tdata[23:0], m_tdata[47:24], m_tdata[72:48], m_tdata[97:73], m_tuser};
			got.new_x = m_tdata[23:0];
			got.new_y = m_tdata[47:24];
			got.move_x = m_tdata[72:48];
			got.move_y = m_tdata[97:73];
			got.arrived = m_tuser;
			if (expected_moves.size() == 0) report_mismatch("unexpected transfer", 0, 0);
			else begin
				want = expected_moves.pop_front();
				if (got.new_x !== want.new_x) report_mismatch("new_x", got.new_x, want.new_x);
				if (got.new_y !== want.new_y) report_mismatch("new_y", got.new_y, want.new_y);
				if (got.move_x !== want.move_x)
					report_mismatch("move_x", got.move_x, want.move_x);
				if (got.move_y !== want.move_y)
					report_mismatch("move_y", got.move_y, want.move_y);
				if (got.arrived !== want.arrived)
					report_mismatch("arrived", got.arrived, want.arrived);
			end
		end
	end

	always @(negedge clk) begin
		if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			hold_off = HOLD_CYCLES;
		end
		if (hold_off > 0) begin
			hold_off = hold_off - 1;
			m_tready <= 1'b0;
		end else m_tready <= $urandom_range(99) >= recv_stall_pct;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else idle_cycles <= idle_cycles + 1;
	end

	initial begin
		send_idle_pct = 0; recv_stall_pct = 0;
		s_tvalid = 0; s_tdata = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		dest_x_q = 0; dest_y_q = 0; speed_q = 256; tol_q = 256;
		arst_n = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		test_directed();
		configure(CW'($urandom), CW'($urandom), SPW'($urandom_range(4096)),
			SPW'($urandom_range(1024)));
		test_random(300, 0, 0);
		configure(CW'($signed($urandom_range(8000)) - 4000), 0, 512, 256);
		test_random(300, 67, 0);
		configure(CW'($urandom), CW'($urandom), SPW'($urandom), SPW'($urandom_range(600)));
		test_random(300, 0, 67);
		configure(-2000, 3000, SPW'($urandom_range(2000)), SPW'($urandom_range(300)));
		test_random(200, 7, 7);
		test_backpressure();
		drain();
		if (errors == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
